[rtl/address_table_lru_evict_core_macros.svh]
// ----------------------------------------------------------------------------
// Address table assertion macros
// Shared assertion wrappers for the address table checker.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_TABLE_LRU_EVICT_CORE_MACROS_SVH
`define ADDRESS_TABLE_LRU_EVICT_CORE_MACROS_SVH

// implication checked every clock, muted in reset
`define ATL_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define ATL_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

[rtl/atl_pkg.sv]
// ----------------------------------------------------------------------------
// Address table package
// Operation codes, sequencer states and field widths.
// ----------------------------------------------------------------------------
`default_nettype none
package atl_pkg;

   typedef enum logic [1:0] {
      FUNC_TOUCH  = 2'd0,
      FUNC_LOOKUP = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_FIND,
      ST_FIND_WAIT,
      ST_OLD,
      ST_OLD_WAIT,
      ST_FREE,
      ST_WRITE,
      ST_CLEAR,
      ST_DONE
   } state_type;

   localparam int unsigned LIMIT_W = 11;
   localparam int unsigned SLOT_W  = 10;
   localparam int unsigned KEY_W   = 32;
   localparam int unsigned TIME_W  = 64;

endpackage
`default_nettype wire

[rtl/atl_ram.sv]
// ----------------------------------------------------------------------------
// Address table RAM
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module atl_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule
`default_nettype wire

[rtl/address_table_lru_evict_core.sv]
// ----------------------------------------------------------------------------
// Address table with least-recently-seen eviction
// Slot table of addresses and last-seen stamps, scanned one slot a cycle.
//
//  channel  dir  fields
//  req      in   tdata: func, ip_addr, now_time
//  rsp      out  tdata: hit, slot, evicted, evicted_ip, status, live_count
//  csr      in   entry_limit
//
// Key search: one RAM read per slot; a hit ends the search early.
// Miss insert: key search, oldest search if at the limit, then free search.
// Clear all: one slot marked free per cycle.
// Reset: clearing pass over the valid bits in the key RAM.
// req_tready is high only in idle; low while a beat is in work or the response waits.
// ----------------------------------------------------------------------------
`default_nettype none
module address_table_lru_evict_core #(
   parameter int unsigned TABLE_SLOTS = 1024
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // func[1:0], ip_addr[33:2], now_time[97:34], zero pad
   input  wire logic [103:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // hit[0], slot[10:1], evicted[11], evicted_ip[43:12], status[44],
   // live_count[55:45]
   output logic [55:0]        rsp_tdata,
   input  wire logic          csr_we,
   input  wire logic [10:0]   csr_wdata
);
   localparam int unsigned AW = $clog2(TABLE_SLOTS);
   localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);
   localparam int unsigned KW = atl_pkg::KEY_W + 1;
   localparam int unsigned TW = atl_pkg::TIME_W;
   localparam int unsigned SW = atl_pkg::SLOT_W;
   localparam int unsigned LW = atl_pkg::LIMIT_W;

   atl_pkg::state_type state_ff, state_in;

   logic [LW-1:0]    limit_ff;
   logic [CW-1:0]    total_ff, total_in;
   logic [1:0]       func_ff, func_in;
   logic [KW-2:0]    key_ff, key_in;
   logic [TW-1:0]    now_ff, now_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic             last_ff, last_in;
   logic             best_ok_ff, best_ok_in;
   logic [AW-1:0]    best_ff, best_in;
   logic [TW-1:0]    best_t_ff, best_t_in;
   logic             hit_ff, hit_in;
   logic [AW-1:0]    slot_ff, slot_in;
   logic             ev_ff, ev_in;
   logic [KW-2:0]    evip_ff, evip_in;
   logic             st_ff, st_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [AW-1:0]    rd_idx_ff, rd_idx_in;

   logic             key_we;
   logic             time_we;
   logic [AW-1:0]    ram_addr;
   logic [KW-1:0]    key_wdata;
   logic [KW-1:0]    key_rd;
   logic [TW-1:0]    time_rd;
   logic [CW-1:0]    lim_eff;
   logic             last_idx;
   logic             key_match;

   // key RAM word: live bit on top, address below
   atl_ram #(.WIDTH(KW), .DEPTH(TABLE_SLOTS)) u_key_ram (
      .clock(clock), .we(key_we), .addr(ram_addr), .wdata(key_wdata), .rdata(key_rd));
   atl_ram #(.WIDTH(TW), .DEPTH(TABLE_SLOTS)) u_time_ram (
      .clock(clock), .we(time_we), .addr(ram_addr), .wdata(now_ff), .rdata(time_rd));

   always_comb begin
      if (limit_ff == 11'd0) begin
         lim_eff = CW'(1);
      end else if (32'(limit_ff) > 32'(TABLE_SLOTS)) begin
         lim_eff = CW'(TABLE_SLOTS);
      end else begin
         lim_eff = CW'(limit_ff);
      end
      last_idx  = (idx_ff == AW'(TABLE_SLOTS - 1));
      key_match = rd_valid_ff && key_rd[KW-1] && (key_rd[KW-2:0] == key_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= atl_pkg::ST_INIT;
         limit_ff    <= 11'd1024;
         total_ff    <= '0;
         idx_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         total_ff    <= total_in;
         idx_ff      <= idx_in;
         rd_valid_ff <= rd_valid_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
      func_ff    <= func_in;
      key_ff     <= key_in;
      now_ff     <= now_in;
      last_ff    <= last_in;
      best_ok_ff <= best_ok_in;
      best_ff    <= best_in;
      best_t_ff  <= best_t_in;
      hit_ff     <= hit_in;
      slot_ff    <= slot_in;
      ev_ff      <= ev_in;
      evip_ff    <= evip_in;
      st_ff      <= st_in;
      rd_idx_ff  <= rd_idx_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         atl_pkg::ST_INIT: begin
            if (last_idx) begin
               state_in = atl_pkg::ST_IDLE;
            end
         end
         atl_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (atl_pkg::func_type'(req_tdata[1:0]) == atl_pkg::FUNC_CLEAR)
                        ? atl_pkg::ST_CLEAR : atl_pkg::ST_FIND;
            end
         end
         atl_pkg::ST_FIND: begin
            if (key_match) begin
               state_in = atl_pkg::ST_DONE;
            end else if (last_ff) begin
               state_in = atl_pkg::ST_FIND_WAIT;
            end
         end
         atl_pkg::ST_FIND_WAIT: begin
            if (key_match) begin
               state_in = atl_pkg::ST_DONE;
            end else if (atl_pkg::func_type'(func_ff) != atl_pkg::FUNC_TOUCH) begin
               state_in = atl_pkg::ST_DONE;
            end else if (total_ff >= lim_eff && total_ff != '0) begin
               state_in = atl_pkg::ST_OLD;
            end else begin
               state_in = atl_pkg::ST_FREE;
            end
         end
         atl_pkg::ST_OLD: begin
            if (last_ff) begin
               state_in = atl_pkg::ST_OLD_WAIT;
            end
         end
         atl_pkg::ST_OLD_WAIT: state_in = atl_pkg::ST_FREE;
         atl_pkg::ST_FREE: begin
            if (rd_valid_ff && !key_rd[KW-1]) begin
               state_in = atl_pkg::ST_WRITE;
            end else if (last_ff) begin
               state_in = atl_pkg::ST_DONE;
            end
         end
         atl_pkg::ST_WRITE: state_in = atl_pkg::ST_DONE;
         atl_pkg::ST_CLEAR: begin
            if (last_idx) begin
               state_in = atl_pkg::ST_DONE;
            end
         end
         atl_pkg::ST_DONE: begin
            if (rsp_tready) begin
               state_in = atl_pkg::ST_IDLE;
            end
         end
         default: state_in = atl_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      total_in    = total_ff;
      func_in     = func_ff;
      key_in      = key_ff;
      now_in      = now_ff;
      idx_in      = idx_ff;
      last_in     = last_ff;
      best_ok_in  = best_ok_ff;
      best_in     = best_ff;
      best_t_in   = best_t_ff;
      hit_in      = hit_ff;
      slot_in     = slot_ff;
      ev_in       = ev_ff;
      evip_in     = evip_ff;
      st_in       = st_ff;
      rd_valid_in = 1'b0;
      rd_idx_in   = idx_ff;
      key_we      = 1'b0;
      time_we     = 1'b0;
      ram_addr    = idx_ff;
      key_wdata   = {1'b1, key_ff};
      unique case (state_ff)
         atl_pkg::ST_INIT, atl_pkg::ST_CLEAR: begin
            key_we    = 1'b1;
            key_wdata = '0;
            idx_in    = idx_ff + AW'(1);
            total_in  = '0;
         end
         atl_pkg::ST_IDLE: begin
            func_in = req_tdata[1:0];
            key_in  = req_tdata[33:2];
            now_in  = req_tdata[97:34];
            idx_in  = '0;
            last_in = 1'b0;
            hit_in  = 1'b0;
            slot_in = '0;
            ev_in   = 1'b0;
            evip_in = '0;
            st_in   = 1'b0;
            best_ok_in = 1'b0;
         end
         atl_pkg::ST_FIND, atl_pkg::ST_FIND_WAIT: begin
            if (state_ff == atl_pkg::ST_FIND) begin
               rd_valid_in = 1'b1;
               last_in     = last_idx;
               idx_in      = idx_ff + AW'(1);
            end
            if (key_match) begin
               hit_in      = 1'b1;
               rd_valid_in = 1'b0;
               unique case (atl_pkg::func_type'(func_ff))
                  atl_pkg::FUNC_TOUCH: begin
                     slot_in  = rd_idx_ff;
                     time_we  = 1'b1;
                     ram_addr = rd_idx_ff;
                  end
                  atl_pkg::FUNC_LOOKUP: slot_in = rd_idx_ff;
                  atl_pkg::FUNC_REMOVE: begin
                     key_we    = 1'b1;
                     ram_addr  = rd_idx_ff;
                     key_wdata = {1'b0, key_ff};
                     if (total_ff != '0) begin
                        total_in = total_ff - CW'(1);
                     end
                  end
                  default: ;
               endcase
            end else if (state_ff == atl_pkg::ST_FIND_WAIT) begin
               idx_in  = '0;
               last_in = 1'b0;
               if (atl_pkg::func_type'(func_ff) != atl_pkg::FUNC_TOUCH) begin
                  st_in = 1'b1;
               end
            end
         end
         atl_pkg::ST_OLD, atl_pkg::ST_OLD_WAIT: begin
            if (state_ff == atl_pkg::ST_OLD) begin
               rd_valid_in = 1'b1;
               last_in     = last_idx;
               idx_in      = idx_ff + AW'(1);
            end
            if (rd_valid_ff && key_rd[KW-1]
                && (!best_ok_ff || time_rd < best_t_ff)) begin
               best_ok_in = 1'b1;
               best_in    = rd_idx_ff;
               best_t_in  = time_rd;
               evip_in    = key_rd[KW-2:0];
            end
            if (state_ff == atl_pkg::ST_OLD_WAIT) begin
               idx_in  = '0;
               last_in = 1'b0;
               if (best_ok_in) begin
                  ev_in     = 1'b1;
                  key_we    = 1'b1;
                  ram_addr  = best_in;
                  key_wdata = {1'b0, evip_in};
                  total_in  = total_ff - CW'(1);
               end
            end
         end
         atl_pkg::ST_FREE: begin
            if (!last_ff) begin
               rd_valid_in = 1'b1;
               last_in     = last_idx;
               idx_in      = idx_ff + AW'(1);
            end
            if (rd_valid_ff && !key_rd[KW-1]) begin
               slot_in = rd_idx_ff;
            end
         end
         atl_pkg::ST_WRITE: begin
            key_we   = 1'b1;
            time_we  = 1'b1;
            ram_addr = slot_ff;
            total_in = total_ff + CW'(1);
         end
         atl_pkg::ST_DONE: ;
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == atl_pkg::ST_IDLE);
      rsp_tvalid = (state_ff == atl_pkg::ST_DONE);
      rsp_tdata  = {LW'(total_ff), st_ff, evip_ff, ev_ff, SW'(slot_ff), hit_ff};
   end
endmodule
`default_nettype wire

[rtl/atl_checker.sv]
// ----------------------------------------------------------------------------
// Address table port checker
// Port-level properties of the address table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "address_table_lru_evict_core_macros.svh"
module atl_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [103:0] req_tdata,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [55:0]  rsp_tdata
);
   `ATL_ASSERT_IMP(a_excl, clock, reset, rsp_tvalid, !req_tready,
      "ready while response pending")
   `ATL_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "response beat dropped or changed")
   `ATL_ASSERT_NXT(a_busy, clock, reset, req_tvalid && req_tready, !req_tready,
      "second beat accepted during work")
   `ATL_ASSERT_IMP(a_noevict, clock, reset, rsp_tvalid && !rsp_tdata[11],
      rsp_tdata[43:12] == 32'd0, "evicted_ip without eviction")
   `ATL_ASSERT_IMP(a_status, clock, reset, rsp_tvalid && rsp_tdata[44],
      !rsp_tdata[0] && !rsp_tdata[11], "not-found with hit or eviction")
endmodule

bind address_table_lru_evict_core atl_checker u_atl_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .req_tdata(req_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata));
`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Address table testbench
// Drives touch, lookup, remove and clear beats through the request stream
// under several entry limits, predicts each response with a slot-table model
// kept in a scoreboard, and compares every response field by field.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SLOTS      = 1024;
   localparam int unsigned RUN_LIMIT  = 12_000_000;
   localparam int unsigned LONG_HOLD  = 4000;

   typedef struct packed {
      logic [10:0] live_count;
      logic        status;
      logic [31:0] evicted_ip;
      logic        evicted;
      logic [9:0]  slot;
      logic        hit;
   } table_result_type;

   class lru_table_scoreboard_type;
      bit [31:0]        addr_of [SLOTS];
      bit [63:0]        stamp_of[SLOTS];
      bit               in_use  [SLOTS];
      int unsigned      live;
      bit [10:0]        limit_reg;
      table_result_type pending_results[$];
      int unsigned      mismatches;

      function new();
         for (int i = 0; i < SLOTS; i++) in_use[i] = 0;
         live = 0;
         limit_reg = 11'd1024;
         mismatches = 0;
      endfunction

      function int slot_of(bit [31:0] addr);
         for (int i = 0; i < SLOTS; i++)
            if (in_use[i] && addr_of[i] == addr) return i;
         return -1;
      endfunction

      function void note_request(atl_pkg::func_type op, bit [31:0] addr, bit [63:0] stamp);
         table_result_type r;
         int pos, old, lim;
         r = '0;
         pos = slot_of(addr);
         case (op)
            atl_pkg::FUNC_TOUCH: begin
               if (pos >= 0) begin
                  r.hit = 1;
                  stamp_of[pos] = stamp;
                  r.slot = pos[9:0];
               end else begin
                  lim = limit_reg;
                  if (lim == 0) lim = 1;
                  if (lim > SLOTS) lim = SLOTS;
                  if (live >= lim && live > 0) begin
                     old = -1;
                     for (int i = 0; i < SLOTS; i++)
                        if (in_use[i] && (old < 0 || stamp_of[i] < stamp_of[old])) old = i;
                     if (old >= 0) begin
                        r.evicted = 1;
                        r.evicted_ip = addr_of[old];
                        in_use[old] = 0;
                        live--;
                     end
                  end
                  pos = -1;
                  for (int i = 0; i < SLOTS && pos < 0; i++)
                     if (!in_use[i]) pos = i;
                  if (pos >= 0) begin
                     addr_of[pos] = addr;
                     stamp_of[pos] = stamp;
                     in_use[pos] = 1;
                     live++;
                     r.slot = pos[9:0];
                  end
               end
            end
            atl_pkg::FUNC_LOOKUP: begin
               if (pos >= 0) begin
                  r.hit = 1;
                  r.slot = pos[9:0];
               end else r.status = 1;
            end
            atl_pkg::FUNC_REMOVE: begin
               if (pos >= 0) begin
                  r.hit = 1;
                  in_use[pos] = 0;
                  if (live > 0) live--;
               end else r.status = 1;
            end
            default: begin
               for (int i = 0; i < SLOTS; i++) in_use[i] = 0;
               live = 0;
            end
         endcase
         r.live_count = live[10:0];
         pending_results.push_back(r);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         mismatches++;
         $display("%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
      endtask

      task check_result(logic [55:0] data);
         table_result_type got, want;
         got = data;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected beat", data[31:0], 32'd0);
            return;
         end
         want = pending_results.pop_front();
         if (got.hit !== want.hit) report_mismatch("hit", 32'(got.hit), 32'(want.hit));
         if (got.slot !== want.slot) report_mismatch("slot", 32'(got.slot), 32'(want.slot));
         if (got.evicted !== want.evicted)
            report_mismatch("evicted", 32'(got.evicted), 32'(want.evicted));
         if (got.evicted_ip !== want.evicted_ip)
            report_mismatch("evicted_ip", got.evicted_ip, want.evicted_ip);
         if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
         if (got.live_count !== want.live_count)
            report_mismatch("live_count", 32'(got.live_count), 32'(want.live_count));
      endtask
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [55:0]  rsp_tdata;
   logic         csr_we = 0;
   logic [10:0]  csr_wdata = '0;

   lru_table_scoreboard_type sb = new();
   int unsigned cycles = 0;
   bit          sender_quiet = 0;
   bit          receiver_quiet = 0;
   bit          long_hold = 0;
   bit [63:0]   clock_stamp = 0;
   bit [31:0]   addr_pool[12] = '{32'h0, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                                  32'h0A00_0001, 32'h0A00_0002, 32'hC0A8_0101,
                                  32'hC0A8_0102, 32'h8000_0000, 32'h0000_0001,
                                  32'h7F00_0001, 32'hDEAD_BEEF};

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   address_table_lru_evict_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= RUN_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);

   initial begin : receiver
      int unsigned wait_n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            wait_n = LONG_HOLD;
            long_hold = 0;
         end else wait_n = receiver_quiet ? 0 : $urandom_range(0, 16);
         if (wait_n > 0) begin
            rsp_tready <= 0;
            repeat (wait_n) @(negedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   task send_beat(atl_pkg::func_type op, bit [31:0] addr, bit [63:0] stamp);
      int unsigned gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {6'b0, stamp, addr, op};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, addr, stamp);
      @(negedge clock);
   endtask

   task drain_responses();
      req_tvalid <= 0;
      while (sb.pending_results.size() > 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task write_limit(bit [10:0] value);
      drain_responses();
      csr_we    <= 1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 0;
      sb.limit_reg = value;
      @(negedge clock);
   endtask

   function bit [31:0] pick_addr();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return addr_pool[$urandom_range(0, 11)];
   endfunction

   function bit [63:0] next_stamp();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 4) return {$urandom, $urandom};
      if (r < 6) return '1;
      clock_stamp += $urandom_range(0, 3);
      return clock_stamp;
   endfunction

   function atl_pkg::func_type pick_op();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return atl_pkg::FUNC_TOUCH;
      if (r < 75) return atl_pkg::FUNC_LOOKUP;
      if (r < 97) return atl_pkg::FUNC_REMOVE;
      return atl_pkg::FUNC_CLEAR;
   endfunction

   initial begin : main
      bit [10:0] limits[8] = '{11'd2, 11'd0, 11'd1, 11'd3, 11'd2047, 11'd1024, 11'd8, 11'd2};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: extremes of keys and stamps, touch, lookup and remove, misses
      send_beat(atl_pkg::FUNC_LOOKUP, 32'h0, 64'h0);
      send_beat(atl_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, 64'h0);
      send_beat(atl_pkg::FUNC_TOUCH, 32'h0, 64'h0);
      send_beat(atl_pkg::FUNC_TOUCH, 32'hFFFF_FFFF, '1);
      send_beat(atl_pkg::FUNC_TOUCH, 32'h5555_5555, '1);
      send_beat(atl_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 64'h1);
      send_beat(atl_pkg::FUNC_TOUCH, 32'h0, 64'h5555_5555_5555_5555);
      send_beat(atl_pkg::FUNC_REMOVE, 32'h0, 64'h2);
      send_beat(atl_pkg::FUNC_LOOKUP, 32'h0, 64'h3);
      send_beat(atl_pkg::FUNC_TOUCH, 32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
      write_limit(11'd2);
      // limit lowered below the count; oldest stamps at all ones tie
      send_beat(atl_pkg::FUNC_TOUCH, 32'h1234_5678, 64'h10);
      send_beat(atl_pkg::FUNC_TOUCH, 32'h8765_4321, 64'h11);
      send_beat(atl_pkg::FUNC_TOUCH, 32'h8765_4321, '1);
      send_beat(atl_pkg::FUNC_TOUCH, 32'h0000_0001, '1);
      send_beat(atl_pkg::FUNC_TOUCH, 32'h0000_0002, '1);
      send_beat(atl_pkg::FUNC_CLEAR, 32'hFFFF_FFFF, '1);
      send_beat(atl_pkg::FUNC_LOOKUP, 32'h0000_0002, 64'h0);
      write_limit(11'd0);
      send_beat(atl_pkg::FUNC_TOUCH, 32'h0A0A_0A0A, 64'h20);
      send_beat(atl_pkg::FUNC_TOUCH, 32'h0B0B_0B0B, 64'h21);
      send_beat(atl_pkg::FUNC_TOUCH, 32'h0B0B_0B0B, 64'h22);
      write_limit(11'd2047);
      send_beat(atl_pkg::FUNC_TOUCH, 32'h0C0C_0C0C, 64'h23);
      send_beat(atl_pkg::FUNC_TOUCH, 32'h0D0D_0D0D, 64'h24);
      clock_stamp = 64'h100;

      foreach (limits[p]) begin
         write_limit(limits[p]);
         sender_quiet   = (p == 3);
         receiver_quiet = (p == 4);
         if (p == 2) long_hold = 1;
         for (int n = 0; n < 70; n++) send_beat(pick_op(), pick_addr(), next_stamp());
      end

      drain_responses();
      repeat (50) @(negedge clock);
      if (sb.mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule

[sim.f]
+incdir+rtl
rtl/atl_pkg.sv
rtl/atl_ram.sv
rtl/address_table_lru_evict_core.sv
rtl/atl_checker.sv
tb/tb.sv
